FILE: src/lskv_pkg.sv
// Shared constants, codes and types of the linear search key/value table.
package lskv_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ENTRY_W = KEY_BITS + VALUE_BITS;

    // Port field widths.
    localparam int KIND_W   = 3;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACCESS = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic                hit;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
    } t_result;

endpackage

FILE: src/lskv_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module lskv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/lskv_ctrl.sv
// Request sequencer: linear search, insert, delete with shift-down, and clear.
module lskv_ctrl
    import lskv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_result            o_res,
    output logic               o_wr_en,
    output logic [IDX_W-1:0]   o_wr_addr,
    output logic [ENTRY_W-1:0] o_wr_data,
    output logic               o_rd_en,
    output logic [IDX_W-1:0]   o_rd_addr,
    input  logic [ENTRY_W-1:0] i_rd_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_ACT    = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_fill, n_fill;
    logic                  r_cmp_v, n_cmp_v;
    logic                  r_sh_wv, n_sh_wv;
    logic [KIND_W-1:0]     r_kind, n_kind;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [CNT_W-1:0]      r_issue, n_issue;
    logic [IDX_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_slot, n_slot;
    logic [VALUE_BITS-1:0] r_hit_val, n_hit_val;
    logic [VALUE_BITS-1:0] r_res_val, n_res_val;
    logic [STATUS_W-1:0]   r_res_st, n_res_st;
    logic [IDX_W-1:0]      r_sh_wa, n_sh_wa;

    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [VALUE_BITS-1:0] ins_val;

    assign rd_key  = i_rd_data[ENTRY_W-1 -: KEY_BITS];
    assign rd_val  = i_rd_data[VALUE_BITS-1:0];
    assign ins_val = (r_kind == KIND_WRITE) ? r_value : '0;

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_cmp_v   = r_cmp_v;
        n_sh_wv   = r_sh_wv;
        n_kind    = r_kind;
        n_key     = r_key;
        n_value   = r_value;
        n_issue   = r_issue;
        n_cmp_idx = r_cmp_idx;
        n_found   = r_found;
        n_slot    = r_slot;
        n_hit_val = r_hit_val;
        n_res_val = r_res_val;
        n_res_st  = r_res_st;
        n_sh_wa   = r_sh_wa;
        o_wr_en   = 1'b0;
        o_wr_addr = r_slot;
        o_wr_data = {r_key, r_value};
        o_rd_en   = 1'b0;
        o_rd_addr = r_issue[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind  = i_kind;
                    n_key   = KEY_BITS'(i_key);
                    n_value = VALUE_BITS'(i_value);
                    n_issue = '0;
                    n_cmp_v = 1'b0;
                    n_found = 1'b0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // Reads are issued one entry per cycle; each compare sees the
                // data of the read issued in the cycle before.
                if (r_cmp_v && rd_key == r_key) begin
                    n_found   = 1'b1;
                    n_slot    = r_cmp_idx;
                    n_hit_val = rd_val;
                    n_cmp_v   = 1'b0;
                    n_state   = S_ACT;
                end else if (r_issue >= r_fill && !r_cmp_v) begin
                    n_state = S_ACT;
                end else begin
                    o_rd_en   = r_issue < r_fill;
                    n_cmp_v   = o_rd_en;
                    n_cmp_idx = r_issue[IDX_W-1:0];
                    n_issue   = r_issue + CNT_W'(o_rd_en);
                end
            end
            S_ACT: begin
                n_res_val = '0;
                n_res_st  = ST_OK;
                n_state   = S_OUT;
                unique case (r_kind)
                    KIND_ACCESS, KIND_WRITE: begin
                        if (r_found) begin
                            o_wr_en   = r_kind == KIND_WRITE;
                            n_res_val = (r_kind == KIND_WRITE) ? r_value : r_hit_val;
                        end else if (r_fill == CNT_W'(CAPACITY)) begin
                            n_res_st = ST_FULL;
                        end else begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = r_fill[IDX_W-1:0];
                            o_wr_data = {r_key, ins_val};
                            n_res_val = ins_val;
                            n_fill    = r_fill + CNT_W'(1);
                        end
                    end
                    KIND_DELETE: begin
                        if (!r_found) begin
                            n_res_st = ST_ABSENT;
                        end else begin
                            n_issue = CNT_W'(r_slot) + CNT_W'(1);
                            n_sh_wv = 1'b0;
                            n_state = S_SHIFT;
                        end
                    end
                    KIND_CLEAR: begin
                        n_fill = '0;
                    end
                    default: begin
                        n_res_val = r_found ? r_hit_val : '0;
                    end
                endcase
            end
            S_SHIFT: begin
                // Each entry read above the deleted one is written one place
                // lower in the next cycle; reads run ahead of the writes.
                o_rd_en   = r_issue < r_fill;
                o_wr_en   = r_sh_wv;
                o_wr_addr = r_sh_wa;
                o_wr_data = i_rd_data;
                n_sh_wv   = o_rd_en;
                n_sh_wa   = IDX_W'(r_issue - CNT_W'(1));
                n_issue   = r_issue + CNT_W'(o_rd_en);
                if (!o_rd_en && !r_sh_wv) begin
                    n_fill  = r_fill - CNT_W'(1);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_cmp_v <= 1'b0;
            r_sh_wv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_cmp_v <= n_cmp_v;
            r_sh_wv <= n_sh_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_value   <= n_value;
        r_issue   <= n_issue;
        r_cmp_idx <= n_cmp_idx;
        r_found   <= n_found;
        r_slot    <= n_slot;
        r_hit_val <= n_hit_val;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        r_sh_wa   <= n_sh_wa;
    end

    assign o_stall     = r_state != S_IDLE;
    assign o_res_valid = r_state == S_OUT;

    always_comb begin
        o_res.read_value  = VALUE_W'(r_res_val);
        o_res.hit         = r_found;
        o_res.status      = r_res_st;
        o_res.entry_count = COUNT_W'(r_fill);
    end

endmodule

FILE: src/linear_search_key_value_table_unit.sv
// The search reads one entry per cycle until it finds the key or passes the last entry; a
// miss reads every entry. A delete then moves every entry above the deleted one down one place.
// Requests are handled one at a time: the next is accepted in the cycle after the result
// leaves the controller.
// Reset clears the entry count and the control state; the memory is not swept.
// Top level of the linear search key/value table.
module linear_search_key_value_table_unit
    import lskv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [VALUE_W-1:0]  o_read_value,
    output logic                o_hit,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_entry_count
);

    logic               res_valid;
    logic               res_ready;
    t_result            res;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic               r_out_valid;
    t_result            r_out;

    lskv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_kind     (i_kind),
        .i_key      (i_key),
        .i_value    (i_value),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    lskv_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // The output register takes a new result when empty or when its current
    // result transfers in the same cycle.
    assign res_ready = res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_value  = r_out.read_value;
    assign o_hit         = r_out.hit;
    assign o_status      = r_out.status;
    assign o_entry_count = r_out.entry_count;

endmodule

FILE: src/lskv_check.sv
// Port-level assertions for the key/value table, bound to the top level.
module lskv_check
    import lskv_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input logic [VALUE_W-1:0]  o_read_value,
    input logic                o_hit,
    input logic [STATUS_W-1:0] o_status,
    input logic [COUNT_W-1:0]  o_entry_count
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |->
            !o_hit && o_read_value == '0 && o_entry_count == COUNT_W'(CAPACITY))
        else $error("refused insert with inconsistent result");

    a_absent_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_ABSENT |-> !o_hit && o_read_value == '0)
        else $error("absent delete with inconsistent result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_value) && $stable(o_entry_count))
        else $error("stalled result changed");

endmodule

bind linear_search_key_value_table_unit lskv_check u_lskv_check (.*);

FILE: bench/tb_linear_search_key_value_table_unit.sv
// Self-checking testbench of the linear search key/value table with its own table predictor.
module tb_linear_search_key_value_table_unit;
    import lskv_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [KIND_W-1:0]   i_kind = '0;
    logic [KEY_W-1:0]    i_key = '0;
    logic [VALUE_W-1:0]  i_value = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [VALUE_W-1:0]  o_read_value;
    logic                o_hit;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_entry_count;

    // Predicted table contents, updated at each accepted request.
    logic [KEY_W-1:0]   tbl_keys [CAPACITY];
    logic [VALUE_W-1:0] tbl_values [CAPACITY];
    int                 tbl_fill = 0;

    t_result     pending_results [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          quiet = 1'b0;
    bit          valid_held = 1'b0;
    logic [KEY_W-1:0] key_pool [$];

    linear_search_key_value_table_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_read_value  (o_read_value),
        .o_hit         (o_hit),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(99) < 27);
    end

    function automatic t_result predict_table_result(input logic [KIND_W-1:0] kind,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [VALUE_W-1:0] value);
        t_result r;
        int slot;
        int i;
        bit present;
        slot = CAPACITY;
        for (i = 0; i < tbl_fill; i++) begin
            if (slot == CAPACITY && tbl_keys[i] == key) begin
                slot = i;
            end
        end
        present = (slot < CAPACITY);
        r.read_value = '0;
        r.hit = present;
        r.status = ST_OK;
        if (kind == KIND_ACCESS || kind == KIND_WRITE) begin
            if (!present) begin
                if (tbl_fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    slot = tbl_fill;
                    tbl_keys[slot] = key;
                    tbl_values[slot] = '0;
                    tbl_fill++;
                end
            end
            if (r.status == ST_OK) begin
                if (kind == KIND_WRITE) begin
                    tbl_values[slot] = value;
                end
                r.read_value = tbl_values[slot];
            end
        end else if (kind == KIND_DELETE) begin
            if (!present) begin
                r.status = ST_ABSENT;
            end else begin
                for (i = slot; i + 1 < tbl_fill; i++) begin
                    tbl_keys[i] = tbl_keys[i + 1];
                    tbl_values[i] = tbl_values[i + 1];
                end
                tbl_fill--;
            end
        end else if (kind == KIND_CLEAR) begin
            tbl_fill = 0;
        end else if (present) begin
            // Peek and the spare kinds only read.
            r.read_value = tbl_values[slot];
        end
        r.entry_count = tbl_fill[COUNT_W-1:0];
        return r;
    endfunction

    // Offers one request, waits for its transfer and records the expected result.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                                input logic [VALUE_W-1:0] value);
        int gap;
        i_valid <= 1'b1;
        i_kind <= kind;
        i_key <= key;
        i_value <= value;
        valid_held = 1'b1;
        do @(posedge i_clk); while (o_stall);
        pending_results.insert(pending_results.size(), predict_table_result(kind, key, value));
        gap = (quiet || $urandom_range(99) >= 27) ? 0 : $urandom_range(1, 160);
        if (gap > 0) begin
            i_valid <= 1'b0;
            valid_held = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        if (valid_held) begin
            i_valid <= 1'b0;
            valid_held = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [KIND_W-1:0] pick_kind(input int w_peek, input int w_access,
                                                    input int w_write, input int w_delete,
                                                    input int w_clear);
        int r;
        r = $urandom_range(99);
        if (r < w_peek) return KIND_PEEK;
        if (r < w_peek + w_access) return KIND_ACCESS;
        if (r < w_peek + w_access + w_write) return KIND_WRITE;
        if (r < w_peek + w_access + w_write + w_delete) return KIND_DELETE;
        if (r < w_peek + w_access + w_write + w_delete + w_clear) return KIND_CLEAR;
        return KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: read_value %h hit %0d status %0d entry_count %0d",
                       o_read_value, o_hit, o_status, o_entry_count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h", want.read_value, o_read_value);
                    fail_count++;
                end
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count,
                           o_entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Misses, inserts, overwrites, spare kinds, deletes at the start and at the end, and clears.
    task automatic test_directed();
        logic [KIND_W-1:0] k;
        send_request(KIND_PEEK, 32'h0000_0000, 32'h0000_0000);
        send_request(KIND_DELETE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(KIND_ACCESS, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(KIND_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_PEEK, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(KIND_ACCESS, 32'hFFFF_FFFF, 32'h1234_5678);
        send_request(KIND_WRITE, 32'h0000_0000, 32'h8000_0001);
        send_request(KIND_WRITE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(KIND_WRITE, 32'h5555_5555, 32'hAAAA_AAAA);
        send_request(KIND_WRITE, 32'hAAAA_AAAA, 32'h5555_5555);
        k = KIND_SPARE_LO;
        send_request(k, 32'h0000_0000, 32'hFFFF_FFFF);
        k = k + 1'b1;
        send_request(k, 32'h0001_2345, 32'hFFFF_FFFF);
        k = KIND_SPARE_HI;
        send_request(k, 32'hAAAA_AAAA, 32'h0000_0000);
        send_request(KIND_DELETE, 32'h0000_0000, 32'h0000_0000);
        send_request(KIND_PEEK, 32'h5555_5555, 32'h0000_0000);
        send_request(KIND_DELETE, 32'hAAAA_AAAA, 32'h0000_0000);
        send_request(KIND_DELETE, 32'hAAAA_AAAA, 32'h0000_0000);
        send_request(KIND_CLEAR, 32'h5555_5555, 32'hFFFF_FFFF);
        send_request(KIND_CLEAR, 32'h5555_5555, 32'h0000_0000);
        send_request(KIND_PEEK, 32'h5555_5555, 32'h0000_0000);
        send_request(KIND_ACCESS, 32'h5555_5555, 32'hFFFF_FFFF);
        send_request(KIND_DELETE, 32'h5555_5555, 32'h0000_0000);
    endtask

    // Small key set so that hits and deletes of present keys are common.
    task automatic test_small_key_set();
        int n;
        logic [KEY_W-1:0] key;
        key_pool.delete();
        key_pool.insert(key_pool.size(), 32'h0000_0000);
        key_pool.insert(key_pool.size(), 32'hFFFF_FFFF);
        repeat (14) key_pool.insert(key_pool.size(), $urandom);
        for (n = 0; n < 600; n++) begin
            // The first stretch runs with neither side idling.
            quiet = (n < 200);
            key = ($urandom_range(9) == 0) ? $urandom
                                           : key_pool[$urandom_range(key_pool.size() - 1)];
            send_request(pick_kind(18, 20, 25, 22, 3), key, $urandom);
        end
        quiet = 1'b0;
    endtask

    // Fills the table, runs into refusals, then deletes at the ends and the middle.
    task automatic test_full_table();
        int round;
        logic [KEY_W-1:0] key;
        for (round = 0; round < 5; round++) begin
            send_request(KIND_CLEAR, $urandom, $urandom);
            repeat (CAPACITY) send_request(KIND_WRITE, $urandom, $urandom);
            repeat (6) send_request($urandom_range(1) ? KIND_WRITE : KIND_ACCESS,
                                    $urandom, $urandom);
            repeat (10) send_request(pick_kind(30, 30, 30, 0, 0),
                                     tbl_keys[$urandom_range(tbl_fill - 1)], $urandom);
            send_request(KIND_DELETE, tbl_keys[tbl_fill - 1], $urandom);
            send_request(KIND_DELETE, tbl_keys[$urandom_range(1, tbl_fill - 2)], $urandom);
            repeat (3) send_request(KIND_WRITE, $urandom, $urandom);
            key = tbl_keys[0];
            send_request(KIND_DELETE, key, $urandom);
            send_request(KIND_PEEK, key, $urandom);
            send_request(KIND_DELETE, key, $urandom);
            wait_for_results();
        end
    endtask

    // Key set larger than the table, weighted toward inserts so that it runs full.
    task automatic test_large_key_set();
        key_pool.delete();
        repeat (96) key_pool.insert(key_pool.size(), $urandom);
        repeat (470) begin
            send_request(pick_kind(15, 25, 36, 20, 1),
                         key_pool[$urandom_range(key_pool.size() - 1)], $urandom);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_for_results();
        test_small_key_set();
        test_full_table();
        test_large_key_set();
        wait_for_results();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
